@@ rtl/ile_pkg.sv @@
// shared types and codes for the indexed list engine
// no dependencies
package ile_pkg;

  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_HEAD   = 3'd1,
    OP_TAIL   = 3'd2,
    OP_INDEX  = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  localparam logic [31:0] NO_VALUE = 32'hFFFF_FFFF;

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic ins;
    logic del;
    logic get;
  } cell_ctl_t;

endpackage

@@ rtl/ile_if.sv @@
// valid/ready channel interfaces for request and response items
// depends on nothing
interface ile_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  operation;
  logic signed [7:0]  position;
  logic signed [31:0] item_value;

  modport source (output valid, operation, position, item_value, input ready);
  modport sink   (input valid, operation, position, item_value, output ready);
endinterface

interface ile_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] read_value;
  logic        [6:0]  element_count;

  modport source (output valid, status, read_value, element_count, input ready);
  modport sink   (input valid, status, read_value, element_count, output ready);
endinterface

@@ rtl/indexed_list_engine_top.sv @@
// indexed list engine: ordered list of signed 32-bit values in a row of cells
// the response is registered and valid in the cycle after a request is accepted; throughput 1 item per cycle
// while the response sink is ready, set by the parallel shift of the cell row (all cells at or above
// the position move at once); reset clears the element count and the response valid flag; cell contents
// are undefined until written and are never read at or above the count
module indexed_list_engine_top import ile_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ile_in_if.sink    in_if,
  ile_out_if.source out_if
);

  localparam int CW = $clog2(CAPACITY + 1);   // count width, holds CAPACITY itself
  localparam int SW = ((CW > 8) ? CW : 8) + 1; // signed compare width

  // element count
  logic [CW-1:0] count_r, count_nxt;

  // response register
  logic          out_valid_r;
  status_t       status_r;
  logic [31:0]   read_r;
  logic [6:0]    ecount_r;

  logic          acc;
  op_t           op;
  logic signed [SW-1:0] pos_s, cnt_s;
  logic          in_range, full;
  logic          want_ins, want_del, want_get;
  logic [CW-1:0] at;
  status_t       status;
  cell_ctl_t     ctl;

  logic [31:0]   cell_val [CAPACITY];
  logic [31:0]   cell_rd  [CAPACITY];
  logic [31:0]   rd_or;
  logic [CW+6:0] ecount_ext;

  // next request is taken whenever the response slot is free or draining
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign acc         = in_if.valid && in_if.ready;
  assign op          = op_t'(in_if.operation);

  // sign-extend position, zero-extend count for a common signed compare
  assign pos_s    = {{(SW-8){in_if.position[7]}}, in_if.position};
  assign cnt_s    = {{(SW-CW){1'b0}}, count_r};
  assign in_range = !pos_s[SW-1] && (pos_s < cnt_s);
  assign full     = (count_r == CW'(CAPACITY));

  // request decode: placement and status
  always_comb begin
    want_ins = 1'b0;
    want_del = 1'b0;
    want_get = 1'b0;
    at       = '0;
    status   = ST_BADPOS;
    case (op)
      OP_GET: begin
        if (in_range) begin
          want_get = 1'b1;
          at       = pos_s[CW-1:0];
          status   = ST_DONE;
        end
      end
      OP_HEAD: begin
        want_ins = 1'b1;
        at       = '0;
      end
      OP_TAIL: begin
        want_ins = 1'b1;
        at       = count_r;
      end
      OP_INDEX: begin
        // equal to count appends, zero or below prepends, beyond count is rejected
        if (pos_s == cnt_s) begin
          want_ins = 1'b1;
          at       = count_r;
        end else if (pos_s[SW-1] || (pos_s == '0)) begin
          want_ins = 1'b1;
          at       = '0;
        end else if (pos_s < cnt_s) begin
          want_ins = 1'b1;
          at       = pos_s[CW-1:0];
        end
      end
      OP_DELETE: begin
        if (in_range) begin
          want_del = 1'b1;
          at       = pos_s[CW-1:0];
          status   = ST_DONE;
        end
      end
      default: begin
        status = ST_BADPOS;
      end
    endcase
    // insert into a full list is dropped
    if (want_ins) begin
      if (full) begin
        want_ins = 1'b0;
        status   = ST_FULL;
      end else begin
        status   = ST_DONE;
      end
    end
  end

  // command broadcast to the row; insert and delete only on an accepted item
  assign ctl.ins = acc && want_ins;
  assign ctl.del = acc && want_del;
  assign ctl.get = want_get;

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // the cell row: each cell at or above the position takes from its left neighbor on insert
  // (the addressed cell takes the new item), from its right neighbor on delete
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = in_if.item_value;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end
    ile_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .at         (at),
      .item_value (in_if.item_value),
      .left_val   (left_v),
      .right_val  (right_v),
      .val_o      (cell_val[g]),
      .rd_o       (cell_rd[g])
    );
  end

  // only the addressed cell drives a nonzero read, so an or-tree selects it
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign ecount_ext = {7'b0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status;
      read_r   <= want_get ? rd_or : NO_VALUE;
      ecount_r <= ecount_ext[6:0];
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = status_r;
  assign out_if.read_value    = read_r;
  assign out_if.element_count = ecount_r;

endmodule

@@ rtl/ile_cell.sv @@
// one list slot: holds an element and shifts with its neighbors on insert/delete
// depends on ile_pkg
module ile_cell import ile_pkg::*; #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [CW-1:0] at,
  input  logic [31:0]   item_value,
  input  logic [31:0]   left_val,
  input  logic [31:0]   right_val,
  output logic [31:0]   val_o,
  output logic [31:0]   rd_o
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [31:0] val_r;
  logic        at_or_above;
  logic        at_here;

  assign at_or_above = (IDX_C >= at);
  assign at_here     = (IDX_C == at);

  always_ff @(posedge clk) begin
    if (ctl.ins && at_or_above) begin
      val_r <= at_here ? item_value : left_val;
    end else if (ctl.del && at_or_above) begin
      val_r <= right_val;
    end
  end

  assign val_o = val_r;
  assign rd_o  = (ctl.get && at_here) ? val_r : '0;

endmodule
